>>> sv/base_to_flow_index_mapper_macros.svh
// Assertion macros for the base-to-flow index mapper.
// Included by the modules that carry concurrent checks; needs clk and arst_n in scope.
`ifndef BASE_TO_FLOW_INDEX_MAPPER_MACROS_SVH
`define BASE_TO_FLOW_INDEX_MAPPER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define BFIM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define BFIM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/bfim_pkg.sv
// Shared types and constants for the base-to-flow index mapper.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package bfim_pkg;

	localparam int MAX_FLOWS = 1024;
	localparam int ADDR_W    = $clog2(MAX_FLOWS);
	localparam int FLOW_W    = 11;
	localparam int CHAR_W    = 8;
	localparam int TADDR_W   = 10;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_MAP   = 2'd2
	} bfim_op_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_CMP   = 4'b0100,
		ST_EMIT  = 4'b1000
	} bfim_state_t;

	typedef struct packed {
		bfim_op_t            op;
		logic [TADDR_W-1:0]  table_addr;
		logic [CHAR_W-1:0]   char_code;
		logic [TADDR_W-1:0]  first_flow;
	} bfim_in_t;

	typedef struct packed {
		logic [FLOW_W-1:0] matched_flow;
		logic              overflow_error;
	} bfim_out_t;

endpackage

>>> sv/bfim_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
`timescale 1ns / 1ps

module bfim_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/base_to_flow_index_mapper.sv
// Base-to-flow index mapper: flow-order table in RAM, walk sequencer, result register.
// Depends on bfim_pkg, bfim_ram and base_to_flow_index_mapper_macros.svh.
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_stall    in_item  (bfim_in_t)
//  out      source     out_valid / out_stall  out_item (bfim_out_t)
//  cfg      sink       cfg_wr_en              cfg_wr_data (flow count)
//
// Load and start transactions complete on their accept and do not stall the input. A map
// transaction walks the flow order from the current flow: for each entry the end check
// issues the RAM read, then the compare tests the char code; a match, or reaching the end
// of the flow order, moves on to emit, which waits for a free result register.
// Reset idles the sequencer, clears the current flow and sets the flow count to 1024;
// the table has no clearing.
// in_stall is high while a map transaction walks or waits for a free result register.
// A finished result waits in the output register while new transactions are taken.
`timescale 1ns / 1ps

`include "base_to_flow_index_mapper_macros.svh"

module base_to_flow_index_mapper
	import bfim_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  bfim_in_t          in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output bfim_out_t         out_item,
	input  logic              cfg_wr_en,
	input  logic [FLOW_W-1:0] cfg_wr_data
);

	bfim_state_t         state_q;
	logic [FLOW_W-1:0]   flow_count_q;
	logic [FLOW_W-1:0]   cur_q;
	logic                out_valid_q;
	bfim_out_t           out_item_q;
	logic [CHAR_W-1:0]   ch_q;
	logic [FLOW_W-1:0]   flow_q;
	logic                first_q;
	logic [FLOW_W-1:0]   res_flow_q;
	logic                res_err_q;

	logic                in_accept;
	logic                out_accept;
	logic                load_ok;
	logic [FLOW_W-1:0]   eff;
	logic                at_end;
	logic                ram_we;
	logic                ram_re;
	logic [CHAR_W-1:0]   ram_rdata;

	assign in_stall   = (state_q != ST_IDLE);
	assign in_accept  = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign out_item   = out_item_q;
	assign out_accept = out_valid_q && !out_stall;

	// Flow count in use saturates at the table depth.
	assign eff    = (int'(flow_count_q) > MAX_FLOWS) ? FLOW_W'(MAX_FLOWS) : flow_count_q;
	assign at_end = (flow_q >= eff);

	assign load_ok = (int'(in_item.table_addr) < MAX_FLOWS);
	assign ram_we  = in_accept && (in_item.op == OP_LOAD) && load_ok;
	assign ram_re  = (state_q == ST_CHECK) && !at_end;

	bfim_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(MAX_FLOWS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ADDR_W'(in_item.table_addr)),
		.wdata(in_item.char_code),
		.re   (ram_re),
		.raddr(ADDR_W'(flow_q)),
		.rdata(ram_rdata)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			flow_count_q <= FLOW_W'(1024);
			cur_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				flow_count_q <= cfg_wr_data;
			end
			if ((state_q == ST_EMIT) && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_accept) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						case (in_item.op)
							OP_START: cur_q   <= FLOW_W'(in_item.first_flow);
							OP_MAP:   state_q <= ST_CHECK;
							default:  ;
						endcase
					end
				end
				ST_CHECK: begin
					if (at_end) begin
						// walk ran off the flow order; a start past the end leaves the flow alone
						if (!first_q) begin
							cur_q <= flow_q;
						end
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (ram_rdata == ch_q) begin
						cur_q   <= flow_q;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					ch_q    <= in_item.char_code;
					flow_q  <= cur_q;
					first_q <= 1'b1;
				end
			end
			ST_CHECK: begin
				if (at_end) begin
					res_flow_q <= first_q ? eff : flow_q;
					res_err_q  <= first_q;
				end
			end
			ST_CMP: begin
				if (ram_rdata == ch_q) begin
					res_flow_q <= flow_q;
					res_err_q  <= 1'b0;
				end else begin
					// advance to the next flow
					flow_q  <= flow_q + FLOW_W'(1);
					first_q <= 1'b0;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					out_item_q.matched_flow   <= res_flow_q;
					out_item_q.overflow_error <= res_err_q;
				end
			end
			default: ;
		endcase
	end

	`BFIM_ASSERT_NEXT(a_map_enters_walk, in_accept && (in_item.op == OP_MAP), state_q == ST_CHECK, "map transaction did not start the walk")
	`BFIM_ASSERT_NOW(a_cmp_after_read, state_q == ST_CMP, $past(state_q) == ST_CHECK, "compare without a table read")
	`BFIM_ASSERT_NOW(a_result_from_emit, $rose(out_valid_q), $past(state_q) == ST_EMIT, "result appeared outside emit")
	`BFIM_ASSERT_NOW(a_index_in_range, out_valid_q && !out_item_q.overflow_error, out_item_q.matched_flow <= eff, "flow index past flow count")

endmodule
